>>> sv/ttb_pkg.sv
// Package for the triangle tangent/binormal pipeline: widths, divider lane
// types and the per-step divide and final rounding functions.
// No dependencies.
package ttb_pkg;

    localparam int COORD_W   = 32;
    localparam int UVH_W     = 16;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int UV_W      = UVH_W + 1;
    localparam int PROD_W    = EDGE_W + UV_W;
    localparam int NUM_W     = PROD_W + 1;
    localparam int DET_W     = 2 * UV_W + 1;
    localparam int THR_W     = 24;
    localparam int FRAC_SH   = 13;
    localparam int Q_W       = 34;
    localparam int DIV_STEPS = Q_W;
    localparam int LANES     = 6;
    localparam int HI_W      = NUM_W + FRAC_SH - Q_W;
    localparam int FRONT     = 4;
    localparam int NST       = FRONT + DIV_STEPS + 1;

    localparam logic [COORD_W-1:0] ONE_Q16 = COORD_W'(32'h0001_0000);
    localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] NEG_MAX = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic [DET_W-1:0] rem;
        logic [Q_W-1:0]   sh;
        logic             neg;
        logic             ovf;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0] lane;
        logic [DET_W-1:0]  den;
        logic              degen;
    } div_t;

    typedef struct packed {
        logic [COORD_W-1:0] val;
        logic               sat;
    } comp_t;

    // One restoring-division step: pull the next dividend bit, subtract if it fits.
    function automatic lane_t div_step(lane_t a, logic [DET_W-1:0] d);
        lane_t            r;
        logic [DET_W:0]   t;
        logic             qb;
        r  = a;
        t  = {a.rem, a.sh[Q_W-1]};
        qb = (t >= {1'b0, d});
        if (qb)
            t = t - {1'b0, d};
        r.rem = t[DET_W-1:0];
        r.sh  = {a.sh[Q_W-2:0], qb};
        return r;
    endfunction

    // Round half away from zero, apply sign, saturate.
    function automatic comp_t finish(lane_t l);
        comp_t        c;
        logic [Q_W:0] s;
        logic [Q_W-1:0] q;
        logic         big_pos;
        logic         big_neg;
        s = {1'b0, l.sh} + (Q_W+1)'(1);
        q = s[Q_W:1];
        big_pos = (q[Q_W-1:COORD_W-1] != '0);
        big_neg = (q[Q_W-1:COORD_W] != '0) ||
                  (q[COORD_W-1] && (q[COORD_W-2:0] != '0));
        c.sat = 1'b0;
        if (!l.neg)
        begin
            if (l.ovf || big_pos)
            begin
                c.val = POS_MAX;
                c.sat = 1'b1;
            end
            else
                c.val = q[COORD_W-1:0];
        end
        else
        begin
            if (l.ovf || big_neg)
            begin
                c.val = NEG_MAX;
                c.sat = 1'b1;
            end
            else
                c.val = COORD_W'(0) - q[COORD_W-1:0];
        end
        return c;
    endfunction

endpackage

>>> sv/triangle_tangent_binormal.sv
// Triangle tangent/binormal pipeline, top level and only module.
// Depends on ttb_pkg.
//
// Usage:
// - s_* stream carries one triangle per beat. s_tdata, from bit 0 up:
//   p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, uv1, uv2, uv3,
//   32 bits each. Positions are signed Q16.16, each uv packs u (31:16)
//   and v (15:0) as signed Q4.12.
// - m_* stream returns one beat per triangle: tangent_x/y/z then
//   binormal_x/y/z in m_tdata (signed Q16.16, saturated), and in m_tuser
//   degenerate (bit 0) and saturated (bit 1).
// - cfg_wen/cfg_wdata write the degenerate threshold (|det|, unsigned Q0.24);
//   write it only while no triangle is in flight.
// Throughput is one triangle per cycle while m_tready is high. An input
// beat passes four front stages (edges, products, sums,
// magnitude/compare), 34 restoring-divide steps (one quotient bit per
// stage, six lanes sharing the determinant), one round/saturate stage.
// Reset clears all valid bits and the threshold to zero. When m_tready
// is low, stages fill up toward the input: each stage holds its beat only
// if the next is full, so bubbles collapse and s_tready drops only when
// the whole pipe is full.
module triangle_tangent_binormal
    import ttb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [THR_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [383:0]         s_tdata,   // p1_x..p3_z, uv1, uv2, uv3
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [191:0]         m_tdata,   // tangent_x/y/z, binormal_x/y/z
    output logic [1:0]           m_tuser    // degenerate, saturated
);

    logic [THR_W-1:0] thr_reg;
    logic [NST-1:0]   v_reg;
    logic [NST:0]     rdy;

    // Stage A: edges and texcoord deltas
    logic signed [EDGE_W-1:0] e2_reg [3];
    logic signed [EDGE_W-1:0] e3_reg [3];
    logic signed [UV_W-1:0]   du2_reg, dv2_reg, du3_reg, dv3_reg;
    logic signed [EDGE_W-1:0] e2_next [3];
    logic signed [EDGE_W-1:0] e3_next [3];
    logic signed [UV_W-1:0]   du2_next, dv2_next, du3_next, dv3_next;

    // Stage B: products
    logic signed [PROD_W-1:0]  tpa_reg [3];
    logic signed [PROD_W-1:0]  tpb_reg [3];
    logic signed [PROD_W-1:0]  bpa_reg [3];
    logic signed [PROD_W-1:0]  bpb_reg [3];
    logic signed [2*UV_W-1:0]  dpa_reg, dpb_reg;

    // Stage C: numerators and determinant
    logic signed [NUM_W-1:0] num_reg [LANES];
    logic signed [DET_W-1:0] det_reg;

    // Stage D and divide steps
    div_t div_reg [DIV_STEPS+1];
    div_t div_next;

    logic [191:0] out_data_reg;
    logic [1:0]   out_user_reg;
    logic [191:0] out_data_next;
    logic [1:0]   out_user_next;

    // Ready ripples back from the output: a stage takes a beat when it is
    // empty or its own beat moves on.
    always_comb
    begin
        rdy[NST] = m_tready;
        for (int k = NST-1; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[NST-1];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        logic signed [UVH_W-1:0] u1, v1, u2, v2, u3, v3;
        u1 = s_tdata[9*32+16 +: 16];
        v1 = s_tdata[9*32    +: 16];
        u2 = s_tdata[10*32+16 +: 16];
        v2 = s_tdata[10*32    +: 16];
        u3 = s_tdata[11*32+16 +: 16];
        v3 = s_tdata[11*32    +: 16];
        for (int i = 0; i < 3; i++)
        begin
            e2_next[i] = EDGE_W'($signed(s_tdata[(3+i)*32 +: 32]))
                       - EDGE_W'($signed(s_tdata[i*32 +: 32]));
            e3_next[i] = EDGE_W'($signed(s_tdata[(6+i)*32 +: 32]))
                       - EDGE_W'($signed(s_tdata[i*32 +: 32]));
        end
        du2_next = UV_W'(u2) - UV_W'(u1);
        dv2_next = UV_W'(v2) - UV_W'(v1);
        du3_next = UV_W'(u3) - UV_W'(u1);
        dv3_next = UV_W'(v3) - UV_W'(v1);
    end

    // Stage D: magnitudes, degenerate test, divider seed and overflow check.
    always_comb
    begin
        logic [NUM_W-1:0] mag;
        logic [DET_W-1:0] hi;
        div_next.den   = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
        div_next.degen = (div_next.den <= DET_W'(thr_reg));
        for (int l = 0; l < LANES; l++)
        begin
            mag = num_reg[l][NUM_W-1] ? NUM_W'(-num_reg[l]) : NUM_W'(num_reg[l]);
            hi  = DET_W'(mag[NUM_W-1 -: HI_W]);
            div_next.lane[l].rem = hi;
            div_next.lane[l].sh  = {mag[NUM_W-HI_W-1:0], {FRAC_SH{1'b0}}};
            div_next.lane[l].neg = num_reg[l][NUM_W-1] ^ det_reg[DET_W-1];
            div_next.lane[l].ovf = (hi >= div_next.den);
        end
    end

    // Final stage: round, saturate, or drop in the default basis.
    always_comb
    begin
        comp_t c;
        logic  sat;
        c   = '0;
        sat = 1'b0;
        out_data_next = '0;
        if (div_reg[DIV_STEPS].degen)
        begin
            out_data_next[0*32 +: 32]  = ONE_Q16;
            out_data_next[4*32 +: 32]  = ONE_Q16;
        end
        else
        begin
            for (int l = 0; l < LANES; l++)
            begin
                c = finish(div_reg[DIV_STEPS].lane[l]);
                out_data_next[l*32 +: 32] = c.val;
                sat = sat | c.sat;
            end
        end
        out_user_next = {sat, div_reg[DIV_STEPS].degen};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
            v_reg   <= '0;
        end
        else
        begin
            if (cfg_wen)
                thr_reg <= cfg_wdata;
            if (rdy[0])
                v_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++)
            begin
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                e2_reg[i] <= e2_next[i];
                e3_reg[i] <= e3_next[i];
            end
            du2_reg <= du2_next;
            dv2_reg <= dv2_next;
            du3_reg <= du3_next;
            dv3_reg <= dv3_next;
        end
        if (rdy[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                tpa_reg[i] <= PROD_W'(dv3_reg) * PROD_W'(e2_reg[i]);
                tpb_reg[i] <= PROD_W'(dv2_reg) * PROD_W'(e3_reg[i]);
                bpa_reg[i] <= PROD_W'(du2_reg) * PROD_W'(e3_reg[i]);
                bpb_reg[i] <= PROD_W'(du3_reg) * PROD_W'(e2_reg[i]);
            end
            dpa_reg <= (2*UV_W)'(du2_reg) * (2*UV_W)'(dv3_reg);
            dpb_reg <= (2*UV_W)'(du3_reg) * (2*UV_W)'(dv2_reg);
        end
        if (rdy[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i]   <= NUM_W'(tpa_reg[i]) - NUM_W'(tpb_reg[i]);
                num_reg[3+i] <= NUM_W'(bpa_reg[i]) - NUM_W'(bpb_reg[i]);
            end
            det_reg <= DET_W'(dpa_reg) - DET_W'(dpb_reg);
        end
        if (rdy[3])
            div_reg[0] <= div_next;
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            if (rdy[FRONT-1+k])
            begin
                div_reg[k].den   <= div_reg[k-1].den;
                div_reg[k].degen <= div_reg[k-1].degen;
                for (int l = 0; l < LANES; l++)
                    div_reg[k].lane[l] <= div_step(div_reg[k-1].lane[l],
                                                   div_reg[k-1].den);
            end
        end
        if (rdy[NST-1])
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

endmodule
